// File: design/tcce_pkg.sv
// Shared types, constants and saturation helpers for the text console cursor engine.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package tcce_pkg;

    // Cursor coordinate width
    localparam int COORD_BITS = 13;
    localparam int POS_BITS   = 13;
    localparam int DIM_BITS   = 12;
    localparam int FONT_BITS  = 8;
    localparam int CHAR_BITS  = 8;
    localparam int ADV_BITS   = 9;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;
    localparam int DIV_CNT_BITS  = $clog2(DIM_BITS + 1);
    // Wide enough for any coordinate plus an advance, and for any origin plus coordinate
    localparam int WIDE_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [CHAR_BITS-1:0] NL_CODE = 8'd10;
    localparam logic [CHAR_BITS-1:0] CR_CODE = 8'd13;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [WIDE_BITS-1:0]  wide_t;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_FILL   = 2'd3
    } cmd_t;

    typedef enum logic {
        OP_CHAR    = 1'b0,
        OP_CLEARED = 1'b1
    } op_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FONT_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHAR_PADDING  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCROLL_ENABLE = 3'd6;

    typedef struct packed {
        logic [DIM_BITS-1:0]  window_width;
        logic [DIM_BITS-1:0]  window_height;
        logic [DIM_BITS-1:0]  origin_x;
        logic [DIM_BITS-1:0]  origin_y;
        logic [FONT_BITS-1:0] font_height;
        logic [FONT_BITS-1:0] char_padding;
        logic                 scroll_enable;
        coord_t               last_line_y;
        logic                 busy;
    } cfg_t;

    typedef struct packed {
        op_t                  opcode;
        logic [CHAR_BITS-1:0] char_code;
        logic [CHAR_BITS-1:0] glyph_width;
    } item_t;

    typedef struct packed {
        cmd_t                 command;
        pos_t                 pos_x;
        pos_t                 pos_y;
        logic [CHAR_BITS-1:0] glyph;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        coord_t     next_x;
        coord_t     next_y;
        res_t       res;
    } plan_t;

    function automatic coord_t coord_sat(wide_t v);
        coord_t r;
        if (v > wide_t'({COORD_BITS{1'b1}}))
            r = {COORD_BITS{1'b1}};
        else
            r = v[COORD_BITS-1:0];
        return r;
    endfunction

    function automatic pos_t pos_sat(wide_t v);
        pos_t r;
        if (v > wide_t'(POS_MAX))
            r = POS_MAX;
        else
            r = v[POS_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/tcce_item_if.sv
// Input item channel: valid/ready handshake with the character payload.
// Depends on tcce_pkg.
`default_nettype none

interface tcce_item_if;
    logic                           valid;
    logic                           ready;
    tcce_pkg::op_t                  opcode;
    logic [tcce_pkg::CHAR_BITS-1:0] char_code;
    logic [tcce_pkg::CHAR_BITS-1:0] glyph_width;

    modport source (output valid, output opcode, output char_code, output glyph_width,
                    input ready);
    modport sink (input valid, input opcode, input char_code, input glyph_width,
                  output ready);
endinterface

`default_nettype wire

// File: design/tcce_result_if.sv
// Result item channel: valid/ready handshake with one drawing command.
// Depends on tcce_pkg.
`default_nettype none

interface tcce_result_if;
    logic                           valid;
    logic                           ready;
    tcce_pkg::cmd_t                 command;
    tcce_pkg::pos_t                 pos_x;
    tcce_pkg::pos_t                 pos_y;
    logic [tcce_pkg::CHAR_BITS-1:0] glyph;
    logic                           last;

    modport source (output valid, output command, output pos_x, output pos_y, output glyph,
                    output last, input ready);
    modport sink (input valid, input command, input pos_x, input pos_y, input glyph,
                  input last, output ready);
endinterface

`default_nettype wire

// File: design/tcce_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on tcce_pkg.
`default_nettype none

interface tcce_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tcce_pkg::CFG_IDX_BITS-1:0]  index;
    logic [tcce_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/text_console_cursor_engine_top.sv
// Accepted items wait in the item register; results go out through the output register.
// Throughput: one result per cycle while the receiver is ready; a printable item has
//   one to three results, any other item none.
// Reset: cursor to the top-left; after reset and after every configuration write the block
//   takes no item while the last-line position is recomputed.
// Depends on tcce_pkg, tcce_item_if, tcce_result_if, tcce_cfg_if, tcce_cfg, tcce_layout.
`default_nettype none

module text_console_cursor_engine_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcce_cfg_if.sink    cfg,
    tcce_item_if.sink   items,
    tcce_result_if.source results
);

    tcce_pkg::cfg_t   cfg_s;
    tcce_pkg::plan_t  plan;

    // Held item and cursor
    logic             a_valid_reg;
    tcce_pkg::item_t  a_item_reg;
    logic [1:0]       idx_reg;
    tcce_pkg::coord_t cursor_x_reg;
    tcce_pkg::coord_t cursor_y_reg;

    // Output register
    logic             out_valid_reg;
    tcce_pkg::res_t   out_reg;

    tcce_pkg::item_t  in_item;
    logic             out_free;
    logic             load;
    logic             load_last;
    logic             a_release;
    logic             in_accept;

    tcce_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_s)
    );

    tcce_layout u_layout (
        .item     (a_item_reg),
        .cursor_x (cursor_x_reg),
        .cursor_y (cursor_y_reg),
        .cfg      (cfg_s),
        .idx      (idx_reg),
        .plan     (plan)
    );

    assign in_item.opcode      = items.opcode;
    assign in_item.char_code   = items.char_code;
    assign in_item.glyph_width = items.glyph_width;

    // The output register frees up when empty or when its item is being taken
    assign out_free  = !out_valid_reg || results.ready;
    assign load      = a_valid_reg && (plan.count != 2'd0) && out_free;
    assign load_last = (idx_reg == (plan.count - 2'd1));
    // Release the held item once its final result moves out, or at once if it has none
    assign a_release = a_valid_reg && ((plan.count == 2'd0) || (load && load_last));

    // Take a new item in the same cycle as the previous one leaves
    assign items.ready = !cfg_s.busy && (!a_valid_reg || a_release);
    assign in_accept   = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            idx_reg      <= '0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else
        begin
            if (in_accept)
                a_valid_reg <= 1'b1;
            else if (a_release)
                a_valid_reg <= 1'b0;

            // Advance through the command list; restart at the next item
            if (a_release)
                idx_reg <= '0;
            else if (load)
                idx_reg <= idx_reg + 2'd1;

            // Commit the cursor once per item
            if (a_release)
            begin
                cursor_x_reg <= plan.next_x;
                cursor_y_reg <= plan.next_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            a_item_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // The draw is always the final command of an item and carries the last flag
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= plan.res;
    end

    assign results.valid   = out_valid_reg;
    assign results.command = out_reg.command;
    assign results.pos_x   = out_reg.pos_x;
    assign results.pos_y   = out_reg.pos_y;
    assign results.glyph   = out_reg.glyph;
    assign results.last    = out_reg.last;

    // No item enters while the last-line position is being worked out
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !cfg_s.busy)
        else $error("item accepted while line unit busy");

    // The command index never runs past the item's command count
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (idx_reg < plan.count))
        else $error("command index beyond command count");

    // A scroll or fill is always the first command of its item
    a_over_first: assert property (@(posedge clk) disable iff (!rst_n)
        (load && ((plan.res.command == tcce_pkg::CMD_SCROLL)
               || (plan.res.command == tcce_pkg::CMD_FILL))) |-> (idx_reg == 2'd0))
        else $error("overflow command not first");

    // The cursor moves only when an item is retired
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !a_release |=> ($stable(cursor_x_reg) && $stable(cursor_y_reg)))
        else $error("cursor changed without an item retiring");

    // A result flagged last always retires its item
    a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_last) |-> a_release)
        else $error("final result did not retire the item");

endmodule

`default_nettype wire

// File: design/tcce_cfg.sv
// Configuration registers and the serial unit that finds the y of the last full line.
// Depends on tcce_pkg and tcce_cfg_if.
`default_nettype none

module tcce_cfg (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcce_cfg_if.sink    cfg,
    output tcce_pkg::cfg_t cfg_out
);

    logic [tcce_pkg::DIM_BITS-1:0]     window_width_reg;
    logic [tcce_pkg::DIM_BITS-1:0]     window_height_reg;
    logic [tcce_pkg::DIM_BITS-1:0]     origin_x_reg;
    logic [tcce_pkg::DIM_BITS-1:0]     origin_y_reg;
    logic [tcce_pkg::FONT_BITS-1:0]    font_height_reg;
    logic [tcce_pkg::FONT_BITS-1:0]    char_padding_reg;
    logic                              scroll_enable_reg;
    logic                              busy_reg;
    logic [tcce_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [tcce_pkg::FONT_BITS-1:0]    rem_reg;
    tcce_pkg::coord_t                  last_line_y_reg;

    logic                              wr;
    logic [tcce_pkg::DIV_CNT_BITS-1:0] bit_idx;
    logic [tcce_pkg::FONT_BITS:0]      trial;
    logic                              fits;
    logic [tcce_pkg::FONT_BITS-1:0]    rem_next;
    logic [tcce_pkg::DIM_BITS-1:0]     last_raw;
    logic                              has_line;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg  <= 12'd320;
            window_height_reg <= 12'd240;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            font_height_reg   <= 8'd8;
            char_padding_reg  <= 8'd1;
            scroll_enable_reg <= 1'b1;
        end
        else if (wr)
        begin
            unique case (cfg.index)
                tcce_pkg::REG_WINDOW_WIDTH:  window_width_reg  <= cfg.data;
                tcce_pkg::REG_WINDOW_HEIGHT: window_height_reg <= cfg.data;
                tcce_pkg::REG_ORIGIN_X:      origin_x_reg      <= cfg.data;
                tcce_pkg::REG_ORIGIN_Y:      origin_y_reg      <= cfg.data;
                tcce_pkg::REG_FONT_HEIGHT:   font_height_reg   <= cfg.data[tcce_pkg::FONT_BITS-1:0];
                tcce_pkg::REG_CHAR_PADDING:  char_padding_reg  <= cfg.data[tcce_pkg::FONT_BITS-1:0];
                tcce_pkg::REG_SCROLL_ENABLE: scroll_enable_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Restoring remainder of window_height / font_height, one bit per cycle, MSB first
    assign bit_idx  = cnt_reg - tcce_pkg::DIV_CNT_BITS'(1);
    assign trial    = {rem_reg, window_height_reg[bit_idx]};
    assign fits     = trial >= {1'b0, font_height_reg};
    assign rem_next = fits ? tcce_pkg::FONT_BITS'(trial - {1'b0, font_height_reg})
                           : trial[tcce_pkg::FONT_BITS-1:0];

    // lines * font_height = height - rem, so the last line starts at height - rem - font_height
    assign has_line = (font_height_reg != '0)
                   && (window_height_reg >= tcce_pkg::DIM_BITS'(font_height_reg));
    assign last_raw = window_height_reg - tcce_pkg::DIM_BITS'(rem_reg)
                    - tcce_pkg::DIM_BITS'(font_height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= tcce_pkg::DIV_CNT_BITS'(tcce_pkg::DIM_BITS);
            rem_reg  <= '0;
        end
        else if (wr)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= tcce_pkg::DIV_CNT_BITS'(tcce_pkg::DIM_BITS);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= bit_idx;
                rem_reg <= rem_next;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && (cnt_reg == '0))
            last_line_y_reg <= has_line ? tcce_pkg::coord_sat(tcce_pkg::wide_t'(last_raw)) : '0;
    end

    always_comb
    begin
        cfg_out.window_width  = window_width_reg;
        cfg_out.window_height = window_height_reg;
        cfg_out.origin_x      = origin_x_reg;
        cfg_out.origin_y      = origin_y_reg;
        cfg_out.font_height   = font_height_reg;
        cfg_out.char_padding  = char_padding_reg;
        cfg_out.scroll_enable = scroll_enable_reg;
        cfg_out.last_line_y   = last_line_y_reg;
        cfg_out.busy          = busy_reg;
    end

endmodule

`default_nettype wire

// File: design/tcce_layout.sv
// Combinational layout of one held item: wrap, overflow, command list and next cursor.
// Depends on tcce_pkg.
`default_nettype none

module tcce_layout (
    input  wire tcce_pkg::item_t  item,
    input  wire tcce_pkg::coord_t cursor_x,
    input  wire tcce_pkg::coord_t cursor_y,
    input  wire tcce_pkg::cfg_t   cfg,
    input  wire logic [1:0]       idx,
    output tcce_pkg::plan_t       plan
);

    tcce_pkg::wide_t  adv;
    tcce_pkg::wide_t  fh_w;
    logic             is_char;
    logic             is_nl;
    logic             printable;
    logic             wrap;
    tcce_pkg::coord_t nl_y;
    tcce_pkg::coord_t x1;
    tcce_pkg::coord_t y1;
    logic             over;
    tcce_pkg::coord_t x2;
    tcce_pkg::coord_t y2;
    logic             clear;
    logic [1:0]       count;
    tcce_pkg::pos_t   org_x;
    tcce_pkg::pos_t   org_y;
    tcce_pkg::pos_t   line_y;
    tcce_pkg::res_t   r_draw;
    tcce_pkg::res_t   r_clear;
    tcce_pkg::res_t   r_over;
    tcce_pkg::res_t   r_sel;

    assign adv  = tcce_pkg::wide_t'(item.glyph_width) + tcce_pkg::wide_t'(cfg.char_padding);
    assign fh_w = tcce_pkg::wide_t'(cfg.font_height);

    assign is_char   = item.opcode == tcce_pkg::OP_CHAR;
    assign is_nl     = is_char && (item.char_code == tcce_pkg::NL_CODE);
    assign printable = is_char && !is_nl && (item.char_code != tcce_pkg::CR_CODE);

    assign nl_y = tcce_pkg::coord_sat(tcce_pkg::wide_t'(cursor_y) + fh_w);

    // Wrap when the glyph would reach the right edge
    assign wrap = (tcce_pkg::wide_t'(cursor_x) + adv) >= tcce_pkg::wide_t'(cfg.window_width);
    assign x1   = wrap ? '0 : cursor_x;
    assign y1   = wrap ? nl_y : cursor_y;

    assign over = (tcce_pkg::wide_t'(y1) + fh_w) > tcce_pkg::wide_t'(cfg.window_height);
    assign x2   = over ? '0 : x1;
    assign y2   = over ? (cfg.scroll_enable ? cfg.last_line_y : '0) : y1;

    assign clear = x2 == '0;
    assign count = printable ? (2'd1 + {1'b0, over} + {1'b0, clear}) : 2'd0;

    assign org_x  = tcce_pkg::pos_t'(cfg.origin_x);
    assign org_y  = tcce_pkg::pos_t'(cfg.origin_y);
    assign line_y = tcce_pkg::pos_sat(tcce_pkg::wide_t'(cfg.origin_y) + tcce_pkg::wide_t'(y2));

    always_comb
    begin
        r_draw.command = tcce_pkg::CMD_DRAW;
        r_draw.pos_x   = tcce_pkg::pos_sat(tcce_pkg::wide_t'(cfg.origin_x)
                                         + tcce_pkg::wide_t'(x2));
        r_draw.pos_y   = line_y;
        r_draw.glyph   = item.char_code;
        r_draw.last    = 1'b1;

        r_clear.command = tcce_pkg::CMD_CLEAR;
        r_clear.pos_x   = org_x;
        r_clear.pos_y   = line_y;
        r_clear.glyph   = '0;
        r_clear.last    = 1'b0;

        r_over.command = cfg.scroll_enable ? tcce_pkg::CMD_SCROLL : tcce_pkg::CMD_FILL;
        r_over.pos_x   = org_x;
        r_over.pos_y   = org_y;
        r_over.glyph   = '0;
        r_over.last    = 1'b0;

        // Order: overflow command, then line clear, then draw
        unique case (idx)
            2'd0:    r_sel = over ? r_over : (clear ? r_clear : r_draw);
            2'd1:    r_sel = over ? r_clear : r_draw;
            default: r_sel = r_draw;
        endcase
    end

    always_comb
    begin
        plan.count = count;
        plan.res   = r_sel;
        if (!is_char)
        begin
            plan.next_x = '0;
            plan.next_y = '0;
        end
        else if (is_nl)
        begin
            plan.next_x = '0;
            plan.next_y = nl_y;
        end
        else if (printable)
        begin
            plan.next_x = tcce_pkg::coord_sat(tcce_pkg::wide_t'(x2) + adv);
            plan.next_y = y2;
        end
        else
        begin
            plan.next_x = cursor_x;
            plan.next_y = cursor_y;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_text_console_cursor_engine_top.sv
// Self-checking testbench for the text console cursor engine: drives character items and
// register writes, predicts every drawing command and compares them field by field.
// Depends on tcce_pkg, tcce_cfg_if, tcce_item_if, tcce_result_if and the engine top level.

module tb_text_console_cursor_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused register slot: writes to it must leave every setting untouched
    localparam logic [tcce_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    // Generous bound on the whole run; the slowest legal run stays well below it
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to let pass once nothing is expected, so that items without a result
    // (newline, carriage return, window cleared) have left the engine
    localparam int SETTLE_CYCLES = 20;
    localparam int unsigned COORD_TOP = (1 << tcce_pkg::COORD_BITS) - 1;

    logic clk;
    logic rst_n;

    tcce_cfg_if    cfg_bus();
    tcce_item_if   item_bus();
    tcce_result_if res_bus();

    text_console_cursor_engine_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .items   (item_bus),
        .results (res_bus)
    );

    // ------------------------------------------------------------------
    // Clock: 8 ns period
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Layout predictor state: register copies and the pixel cursor,
    // initialised to the reset values of the engine
    // ------------------------------------------------------------------
    int unsigned win_w     = 320;
    int unsigned win_h     = 240;
    int unsigned org_x     = 0;
    int unsigned org_y     = 0;
    int unsigned line_h    = 8;
    int unsigned pad_px    = 1;
    int unsigned scroll_on = 1;
    int unsigned cur_x     = 0;
    int unsigned cur_y     = 0;

    // Drawing commands predicted but not yet seen on the result channel, oldest first
    tcce_pkg::res_t pending_cmds[$];

    int error_count = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    // When set, neither side idles: back-to-back items and an always-ready receiver
    bit calm_mode   = 1'b0;

    task automatic report_error(string msg);
        $display("%0t ns ERROR: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned clamp(int unsigned v, int unsigned top);
        return (v > top) ? top : v;
    endfunction

    // Gap length for either side: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic tcce_pkg::res_t make_command(tcce_pkg::cmd_t c, int unsigned x,
                                                    int unsigned y,
                                                    logic [tcce_pkg::CHAR_BITS-1:0] g);
        tcce_pkg::res_t r;
        r.command = c;
        r.pos_x   = tcce_pkg::pos_t'(clamp(x, tcce_pkg::POS_MAX));
        r.pos_y   = tcce_pkg::pos_t'(clamp(y, tcce_pkg::POS_MAX));
        r.glyph   = g;
        r.last    = 1'b0;
        return r;
    endfunction

    // Advance the cursor for one accepted item and queue the commands it draws
    task automatic layout_item(tcce_pkg::op_t op, logic [tcce_pkg::CHAR_BITS-1:0] code,
                               logic [tcce_pkg::CHAR_BITS-1:0] width);
        int unsigned advance;
        int unsigned lines;
        tcce_pkg::res_t batch[$];
        if (op == tcce_pkg::OP_CLEARED)
        begin
            cur_x = 0;
            cur_y = 0;
            return;
        end
        if (code == tcce_pkg::NL_CODE)
        begin
            // Newline only moves the cursor; the scroll waits for the next glyph
            cur_x = 0;
            cur_y = clamp(cur_y + line_h, COORD_TOP);
            return;
        end
        if (code == tcce_pkg::CR_CODE)
            return;

        advance = width + pad_px;
        // Wrap when the glyph would reach the right edge
        if (cur_x + advance >= win_w)
        begin
            cur_x = 0;
            cur_y = clamp(cur_y + line_h, COORD_TOP);
        end
        // Line below the bottom: scroll one line, or wipe the whole window
        if (cur_y + line_h > win_h)
        begin
            if (scroll_on != 0)
            begin
                lines = (line_h != 0) ? win_h / line_h : 0;
                batch.push_back(make_command(tcce_pkg::CMD_SCROLL, org_x, org_y, '0));
                cur_x = 0;
                cur_y = (lines != 0) ? clamp((lines - 1) * line_h, COORD_TOP) : 0;
            end
            else
            begin
                batch.push_back(make_command(tcce_pkg::CMD_FILL, org_x, org_y, '0));
                cur_x = 0;
                cur_y = 0;
            end
        end
        if (cur_x == 0)
            batch.push_back(make_command(tcce_pkg::CMD_CLEAR, org_x, org_y + cur_y, '0));
        batch.push_back(make_command(tcce_pkg::CMD_DRAW, org_x + cur_x, org_y + cur_y, code));
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            pending_cmds.push_back(batch[i]);
        cur_x = clamp(cur_x + advance, COORD_TOP);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random stalls, mostly short, with calm stretches
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (calm_mode)
            res_bus.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            res_bus.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every accepted command with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_result
        tcce_pkg::res_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_cmds.size() == 0)
                report_error($sformatf("command %0d at (%0d,%0d) with nothing expected",
                                       res_bus.command, res_bus.pos_x, res_bus.pos_y));
            else
            begin
                want = pending_cmds.pop_front();
                if (res_bus.command !== want.command)
                    report_error($sformatf("command: got %0d expected %0d",
                                           res_bus.command, want.command));
                if (res_bus.pos_x !== want.pos_x)
                    report_error($sformatf("pos_x: got %0d expected %0d",
                                           res_bus.pos_x, want.pos_x));
                if (res_bus.pos_y !== want.pos_y)
                    report_error($sformatf("pos_y: got %0d expected %0d",
                                           res_bus.pos_y, want.pos_y));
                if (res_bus.glyph !== want.glyph)
                    report_error($sformatf("glyph: got %0d expected %0d",
                                           res_bus.glyph, want.glyph));
                if (res_bus.last !== want.last)
                    report_error($sformatf("last: got %0b expected %0b",
                                           res_bus.last, want.last));
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item sender and register writer
    // ------------------------------------------------------------------

    // Send one item after a random gap; hold valid high afterwards so that a
    // back-to-back item never drops and raises it in the same step
    task automatic send_item(tcce_pkg::op_t op, logic [tcce_pkg::CHAR_BITS-1:0] code,
                             logic [tcce_pkg::CHAR_BITS-1:0] width);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.opcode      <= op;
        item_bus.char_code   <= code;
        item_bus.glyph_width <= width;
        do
            @(posedge clk);
        while (!item_bus.ready);
        layout_item(op, code, width);
    endtask

    task automatic send_char(logic [tcce_pkg::CHAR_BITS-1:0] code,
                             logic [tcce_pkg::CHAR_BITS-1:0] width);
        send_item(tcce_pkg::OP_CHAR, code, width);
    endtask

    // Drop valid and wait until every predicted command has arrived, then let
    // the engine finish any item that draws nothing
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; valid stays high for a following write
    task automatic write_reg(logic [tcce_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [tcce_pkg::CFG_DATA_BITS-1:0] wdata);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= wdata;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            tcce_pkg::REG_WINDOW_WIDTH:  win_w     = wdata;
            tcce_pkg::REG_WINDOW_HEIGHT: win_h     = wdata;
            tcce_pkg::REG_ORIGIN_X:      org_x     = wdata;
            tcce_pkg::REG_ORIGIN_Y:      org_y     = wdata;
            tcce_pkg::REG_FONT_HEIGHT:   line_h    = wdata[tcce_pkg::FONT_BITS-1:0];
            tcce_pkg::REG_CHAR_PADDING:  pad_px    = wdata[tcce_pkg::FONT_BITS-1:0];
            tcce_pkg::REG_SCROLL_ENABLE: scroll_on = wdata[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_bus.valid <= 1'b0;
    endtask

    // Rewrite every register with raw data; the engine keeps only the low bits
    task automatic configure(logic [tcce_pkg::CFG_DATA_BITS-1:0] ww,
                             logic [tcce_pkg::CFG_DATA_BITS-1:0] wh,
                             logic [tcce_pkg::CFG_DATA_BITS-1:0] ox,
                             logic [tcce_pkg::CFG_DATA_BITS-1:0] oy,
                             logic [tcce_pkg::CFG_DATA_BITS-1:0] fh,
                             logic [tcce_pkg::CFG_DATA_BITS-1:0] pad,
                             logic [tcce_pkg::CFG_DATA_BITS-1:0] se);
        settle();
        write_reg(tcce_pkg::REG_WINDOW_WIDTH, ww);
        write_reg(tcce_pkg::REG_WINDOW_HEIGHT, wh);
        write_reg(tcce_pkg::REG_ORIGIN_X, ox);
        write_reg(tcce_pkg::REG_ORIGIN_Y, oy);
        write_reg(tcce_pkg::REG_FONT_HEIGHT, fh);
        write_reg(tcce_pkg::REG_CHAR_PADDING, pad);
        write_reg(tcce_pkg::REG_SCROLL_ENABLE, se);
        end_writes();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset layout: first glyph clears its line, zero and full glyph widths,
    // carriage return and newline draw nothing, window cleared homes the cursor
    task automatic test_default_layout();
        send_char(8'h41, 8'd7);
        send_char(8'h42, 8'd0);
        send_char(tcce_pkg::CR_CODE, 8'd3);
        send_char(tcce_pkg::NL_CODE, 8'd0);
        send_char(8'h00, 8'hFF);
        send_item(tcce_pkg::OP_CLEARED, 8'hFF, 8'hFF);
        send_char(8'hFF, 8'hFF);
    endtask

    // Largest window, origin, font and padding: widest advance, wrap at the far edge
    task automatic test_large_window();
        configure(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        for (int i = 0; i < 9; i++)
            send_char(8'(8'h20 + 8'(i * 27)), 8'hFF);
    endtask

    // Two-line window: wrap into a scroll (three commands), then the fill mode
    task automatic test_scroll_and_fill();
        configure(12'd20, 12'd20, 12'd100, 12'd50, 12'd8, 12'd1, 12'd1);
        send_char(8'h61, 8'd9);
        send_char(8'h62, 8'd9);
        send_char(8'h63, 8'd9);
        settle();
        // Upper bits set, low bit clear: fill instead of scroll
        write_reg(tcce_pkg::REG_SCROLL_ENABLE, 12'hFFE);
        end_writes();
        send_char(8'h64, 8'd9);
    endtask

    // Zero width, a window shorter than one line, zero font height, unused index
    task automatic test_degenerate_windows();
        configure(12'd0, 12'hFFF, 12'd0, 12'd0, 12'd8, 12'd0, 12'd1);
        send_char(8'h30, 8'd1);
        send_char(8'h31, 8'd0);
        settle();
        write_reg(REG_UNUSED, 12'hFFF);
        end_writes();
        configure(12'd100, 12'd5, 12'd7, 12'd9, 12'd8, 12'd2, 12'd1);
        send_char(8'h32, 8'd4);
        send_char(tcce_pkg::NL_CODE, 8'd4);
        send_char(tcce_pkg::NL_CODE, 8'd4);
        settle();
        // Bit 8 set, font bits clear: zero font height
        write_reg(tcce_pkg::REG_FONT_HEIGHT, 12'h100);
        end_writes();
        send_char(8'h33, 8'd4);
    endtask

    // Enough newlines to drive the cursor past the coordinate range, then draw
    task automatic test_cursor_saturation();
        configure(12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd255, 12'd0, 12'd1);
        repeat ($urandom_range(33, 36))
            send_char(tcce_pkg::NL_CODE, 8'($urandom_range(0, 255)));
        send_char(8'h58, 8'd10);
        send_char(8'h59, 8'd10);
        send_item(tcce_pkg::OP_CLEARED, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        send_char(8'h5A, 8'd10);
    endtask

    // Mostly running text with line breaks; some stray carriage returns,
    // window-cleared events and odd glyph widths as noise
    task automatic send_random_text(int count);
        int r;
        logic [tcce_pkg::CHAR_BITS-1:0] width;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            width = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 15));
            if (r < 3)
                send_item(tcce_pkg::OP_CLEARED, 8'($urandom_range(0, 255)), width);
            else if (r < 13)
                send_char(tcce_pkg::NL_CODE, width);
            else if (r < 18)
                send_char(tcce_pkg::CR_CODE, width);
            else
                send_char(8'($urandom_range(0, 255)), width);
        end
    endtask

    function automatic logic [tcce_pkg::CFG_DATA_BITS-1:0] pick_dimension();
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(16, 400));
    endfunction

    // Random settings per phase with random upper data bits; hold off once in
    // every phase until the engine has drained
    task automatic test_random_text();
        logic [tcce_pkg::CFG_DATA_BITS-1:0] fh;
        logic [tcce_pkg::CFG_DATA_BITS-1:0] pad;
        for (int phase = 0; phase < 8; phase++)
        begin
            fh  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 255))
                                              : 12'($urandom_range(1, 16));
            pad = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 255))
                                              : 12'($urandom_range(0, 3));
            fh[tcce_pkg::CFG_DATA_BITS-1:tcce_pkg::FONT_BITS]  = 4'($urandom_range(0, 15));
            pad[tcce_pkg::CFG_DATA_BITS-1:tcce_pkg::FONT_BITS] = 4'($urandom_range(0, 15));
            configure(pick_dimension(), pick_dimension(),
                      12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                      fh, pad, 12'($urandom_range(0, 4095)));
            calm_mode = (phase == 2 || phase == 5);
            send_random_text(13);
            settle();
            send_random_text(14);
            calm_mode = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Known values on the item and register inputs before the first edge
        rst_n                <= 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= '0;
        cfg_bus.data         <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.opcode      <= tcce_pkg::OP_CHAR;
        item_bus.char_code   <= '0;
        item_bus.glyph_width <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_layout();
        test_large_window();
        test_scroll_and_fill();
        test_degenerate_windows();
        test_cursor_saturation();
        test_random_text();

        settle();
        if (pending_cmds.size() != 0)
            report_error($sformatf("%0d commands never arrived", pending_cmds.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: text_console_cursor_engine_top.f
design/tcce_pkg.sv
design/tcce_item_if.sv
design/tcce_result_if.sv
design/tcce_cfg_if.sv
design/tcce_cfg.sv
design/tcce_layout.sv
design/text_console_cursor_engine_top.sv
tb/sv/tb_text_console_cursor_engine_top.sv
